// ===== src/dshrs_pkg.sv =====
package dshrs_pkg;

  localparam int PhaseW = 4;
  localparam int ActW   = 3;
  localparam int PosW   = 32;
  localparam int VelW   = 23;
  localparam int OffW   = 24;
  localparam int CmdW   = 2;
  localparam int StatW  = 2;
  localparam int RegIdxW = 3;

  // sequencing phases
  localparam logic [PhaseW-1:0] PH_SETUP    = 4'd0;
  localparam logic [PhaseW-1:0] PH_OFFSET   = 4'd1;
  localparam logic [PhaseW-1:0] PH_SPEEDUP  = 4'd2;
  localparam logic [PhaseW-1:0] PH_HOMING   = 4'd3;
  localparam logic [PhaseW-1:0] PH_HOMED    = 4'd4;
  localparam logic [PhaseW-1:0] PH_WAITING  = 4'd5;
  localparam logic [PhaseW-1:0] PH_REL_ONE  = 4'd6;
  localparam logic [PhaseW-1:0] PH_REL_TWO  = 4'd7;
  localparam logic [PhaseW-1:0] PH_RELEASED = 4'd8;

  // drive actions
  localparam logic [ActW-1:0] ACT_NONE = 3'd0;
  localparam logic [ActW-1:0] ACT_MOVE = 3'd1;
  localparam logic [ActW-1:0] ACT_RUN  = 3'd2;
  localparam logic [ActW-1:0] ACT_ARM  = 3'd3;
  localparam logic [ActW-1:0] ACT_STOP = 3'd4;

  localparam logic [CmdW-1:0] CMD_RELEASE = 2'd2;

  localparam logic [StatW-1:0] ST_SETUP   = 2'd0;
  localparam logic [StatW-1:0] ST_WAITING = 2'd1;
  localparam logic [StatW-1:0] ST_MOVING  = 2'd2;

  // configuration register indexes
  localparam logic [RegIdxW-1:0] REG_HOME_OFFSET  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_HOMING_VEL   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_CLOSED_POS   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_FIRST_OPEN   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_SECOND_OPEN  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_FAST_VEL     = 3'd5;
  localparam logic [RegIdxW-1:0] REG_SLOW_VEL     = 3'd6;

  typedef struct packed {
    logic [OffW-1:0] home_offset_steps;
    logic [VelW-1:0] homing_velocity;
    logic [PosW-1:0] closed_position;
    logic [PosW-1:0] first_open_position;
    logic [PosW-1:0] second_open_position;
    logic [VelW-1:0] fast_velocity;
    logic [VelW-1:0] slow_velocity;
  } seq_cfg_t;

  typedef struct packed {
    logic            config_done;
    logic            in_place;
    logic            at_speed;
    logic            stalled;
    logic [PosW-1:0] position_now;
  } drive_in_t;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [PosW-1:0]   target;
    logic [VelW-1:0]   speed;
    logic [PhaseW-1:0] phase;
  } lane_res_t;

endpackage

// ===== src/dshrs_lane.sv =====
module dshrs_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                release_cmd,
  input  dshrs_pkg::seq_cfg_t  cfg,
  input  dshrs_pkg::drive_in_t drv,
  output dshrs_pkg::lane_res_t res
);
  import dshrs_pkg::*;

  logic [PhaseW-1:0] phase;
  logic [PhaseW-1:0] phase_next;
  logic [PosW-1:0]   offset_target;

  // sign-extend the offset; the sum wraps
  assign offset_target = drv.position_now +
                         {{(PosW-OffW){cfg.home_offset_steps[OffW-1]}},
                          cfg.home_offset_steps};

  always_comb begin
    phase_next = phase;
    res.action = ACT_NONE;
    res.target = '0;
    res.speed  = '0;
    unique case (phase)
      PH_SETUP: begin
        if (drv.config_done) begin
          res.action = ACT_MOVE;
          res.target = offset_target;
          res.speed  = cfg.homing_velocity;
          phase_next = PH_OFFSET;
        end
      end
      PH_OFFSET: begin
        if (drv.in_place) begin
          res.action = ACT_RUN;
          res.speed  = cfg.homing_velocity;
          phase_next = PH_SPEEDUP;
        end
      end
      PH_SPEEDUP: begin
        if (drv.at_speed) begin
          res.action = ACT_ARM;
          phase_next = PH_HOMING;
        end
      end
      PH_HOMING: begin
        if (drv.stalled) begin
          res.action = ACT_STOP;
          phase_next = PH_HOMED;
        end
      end
      PH_HOMED: begin
        // keep commanding the closed position until it is reached
        res.action = ACT_MOVE;
        res.target = cfg.closed_position;
        res.speed  = cfg.slow_velocity;
        if (drv.in_place) begin
          phase_next = PH_WAITING;
        end
      end
      PH_WAITING: begin
        if (release_cmd) begin
          res.action = ACT_MOVE;
          res.target = cfg.first_open_position;
          res.speed  = cfg.fast_velocity;
          phase_next = PH_REL_ONE;
        end
      end
      PH_REL_ONE: begin
        if (drv.in_place) begin
          res.action = ACT_MOVE;
          res.target = cfg.first_open_position;
          res.speed  = cfg.fast_velocity;
          phase_next = PH_REL_TWO;
        end
      end
      PH_REL_TWO: begin
        if (drv.in_place) begin
          res.action = ACT_MOVE;
          res.target = cfg.second_open_position;
          res.speed  = cfg.slow_velocity;
          phase_next = PH_RELEASED;
        end
      end
      PH_RELEASED: begin
        if (drv.in_place) begin
          res.action = ACT_MOVE;
          res.target = cfg.closed_position;
          res.speed  = cfg.slow_velocity;
          phase_next = PH_WAITING;
        end
      end
      default: begin
        phase_next = phase;
      end
    endcase
    res.phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SETUP;
    end else if (step) begin
      phase <= phase_next;
    end
  end

endmodule

// ===== src/dshrs_merge.sv =====
module dshrs_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  logic                       out_ready,
  input  dshrs_pkg::lane_res_t        right_res,
  input  dshrs_pkg::lane_res_t        left_res,
  output logic                       out_valid,
  output dshrs_pkg::lane_res_t        right_word,
  output dshrs_pkg::lane_res_t        left_word,
  output logic [dshrs_pkg::StatW-1:0] group_status
);
  import dshrs_pkg::*;

  logic [StatW-1:0] status_next;

  always_comb begin
    if (right_res.phase == PH_SETUP || left_res.phase == PH_SETUP) begin
      status_next = ST_SETUP;
    end else if (right_res.phase == PH_WAITING && left_res.phase == PH_WAITING) begin
      status_next = ST_WAITING;
    end else begin
      status_next = ST_MOVING;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // hold the word while the receiver stalls
  always_ff @(posedge clk) begin
    if (load) begin
      right_word   <= right_res;
      left_word    <= left_res;
      group_status <= status_next;
    end
  end

endmodule

// ===== src/dual_stepper_home_release_sequencer_core.sv =====
// Dual stepper home and release sequencer.
//
// Input channel (in_valid/in_ready): one control tick per word, carrying the
// supervisor command and the flags and position of the right and left drive.
// Output channel (out_valid/out_ready): one word per tick with an action,
// target and speed for each drive and a combined group status.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): always
// ready; writes the homing, position and velocity registers. Write only while
// no tick is outstanding.
//
// The result word is registered: a tick accepted at one edge shows its result
// word after that edge. Throughput is one tick per cycle; the two drive lanes
// decide combinationally and the output register takes a new word whenever
// it is empty or being drained in the same cycle.
// If the receiver stalls, the output word holds and in_ready drops until the
// word is taken; no tick is lost.
// Reset puts both drives in the set-up phase, clears every configuration
// register and empties the output register.
module dual_stepper_home_release_sequencer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  logic               right_config_done,
  input  logic               right_in_place,
  input  logic               right_at_speed,
  input  logic               right_stalled,
  input  logic signed [31:0] right_position_now,
  input  logic               left_config_done,
  input  logic               left_in_place,
  input  logic               left_at_speed,
  input  logic               left_stalled,
  input  logic signed [31:0] left_position_now,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         right_action,
  output logic signed [31:0] right_target,
  output logic [22:0]        right_speed,
  output logic [2:0]         left_action,
  output logic signed [31:0] left_target,
  output logic [22:0]        left_speed,
  output logic [1:0]         group_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import dshrs_pkg::*;

  seq_cfg_t  cfg;
  drive_in_t right_in;
  drive_in_t left_in;
  lane_res_t right_res;
  lane_res_t left_res;
  lane_res_t right_word;
  lane_res_t left_word;
  logic      accept;
  logic      release_cmd;

  assign cfg_ready   = 1'b1;
  assign in_ready    = !out_valid || out_ready;
  assign accept      = in_valid && in_ready;
  assign release_cmd = (cmd == CMD_RELEASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HOME_OFFSET: cfg.home_offset_steps    <= cfg_data[OffW-1:0];
        REG_HOMING_VEL:  cfg.homing_velocity      <= cfg_data[VelW-1:0];
        REG_CLOSED_POS:  cfg.closed_position      <= cfg_data;
        REG_FIRST_OPEN:  cfg.first_open_position  <= cfg_data;
        REG_SECOND_OPEN: cfg.second_open_position <= cfg_data;
        REG_FAST_VEL:    cfg.fast_velocity        <= cfg_data[VelW-1:0];
        REG_SLOW_VEL:    cfg.slow_velocity        <= cfg_data[VelW-1:0];
        default:         cfg <= cfg;
      endcase
    end
  end

  assign right_in = '{config_done:  right_config_done,
                      in_place:     right_in_place,
                      at_speed:     right_at_speed,
                      stalled:      right_stalled,
                      position_now: right_position_now};
  assign left_in  = '{config_done:  left_config_done,
                      in_place:     left_in_place,
                      at_speed:     left_at_speed,
                      stalled:      left_stalled,
                      position_now: left_position_now};

  dshrs_lane u_right (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .release_cmd (release_cmd),
    .cfg         (cfg),
    .drv         (right_in),
    .res         (right_res)
  );

  dshrs_lane u_left (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .release_cmd (release_cmd),
    .cfg         (cfg),
    .drv         (left_in),
    .res         (left_res)
  );

  dshrs_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .out_ready    (out_ready),
    .right_res    (right_res),
    .left_res     (left_res),
    .out_valid    (out_valid),
    .right_word   (right_word),
    .left_word    (left_word),
    .group_status (group_status)
  );

  assign right_action = right_word.action;
  assign right_target = right_word.target;
  assign right_speed  = right_word.speed;
  assign left_action  = left_word.action;
  assign left_target  = left_word.target;
  assign left_speed   = left_word.speed;

endmodule

// ===== src/dshrs_checker.sv =====
module dshrs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  right_action,
  input logic [31:0] right_target,
  input logic [22:0] right_speed,
  input logic [2:0]  left_action,
  input logic [1:0]  group_status
);
  import dshrs_pkg::*;

  // an accepted tick always produces a word on the next cycle
  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick produced no output word");

  // a held word must block new ticks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output word stalled");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(right_target)
                                && $stable(group_status))
    else $error("stalled output word changed");

  // target only carries meaning on a position move
  a_target_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && right_action != ACT_MOVE |-> right_target == '0)
    else $error("right target set without a position move");

  // both drives waiting: only a closing move or nothing can have led there
  a_waiting_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && group_status == ST_WAITING |->
      (right_action == ACT_NONE || right_action == ACT_MOVE) &&
      (left_action == ACT_NONE || left_action == ACT_MOVE) &&
      (right_action == ACT_MOVE || right_speed == '0))
    else $error("waiting status with an unexpected action");

endmodule

bind dual_stepper_home_release_sequencer_core dshrs_checker u_dshrs_checker (.*);
